// File: design/wstm_pkg.sv
// ----------------------------------------------------------------------------
// wstm_pkg
// Shared types, codes and default sizes for the wildcard string table matcher.
// ----------------------------------------------------------------------------
package wstm_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int MAX_LEN_DEF     = 32;

    localparam int CHAR_W   = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_LONG     = 2'd3;

    localparam logic [CHAR_W-1:0] WILDCARD = 8'h3F;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'b001,
        KIND_ENTRY = 3'b010,
        KIND_QUERY = 3'b100
    } kind_t;

    // Control carried from the front stage to the compare stage.
    typedef struct packed {
        logic                is_query;
        logic                cmp;
        logic                last;
        logic                fresh;
        logic                ovl;
        logic [STATUS_W-1:0] status;
    } s1_ctrl_t;

endpackage

// File: design/wildcard_string_table_match_top.sv
// ----------------------------------------------------------------------------
// wildcard_string_table_match_top
// Table of wildcard strings loaded and queried one character per transfer.
// ----------------------------------------------------------------------------
// Input transfers carry one character each: tuser selects entry character,
// query character or table clear and marks an empty string, tlast ends the
// string. An entry string, when it ends, produces one result transfer with
// its store status; a query string produces one result with the 1-based
// index of the first stored entry of equal length that agrees at every
// position, '?' on either side matching any character.
// One character is taken per cycle unless input is refused on a stall, the
// rate being set by the per-entry character RAMs, which are all read at the
// current position in parallel. A result passes the compare stage and then
// the output register to the master side, two register stages in all.
// After reset the table is empty and no string is in progress; the stored
// characters are not cleared but are only ever read for entries written.
// When the receiver stalls, the result is held in the output register and
// transfers are still accepted into the compare stage; input is refused
// only once that stage also holds a result that cannot move on.
// ----------------------------------------------------------------------------
module wildcard_string_table_match_top #(
    parameter int NUM_ENTRIES = wstm_pkg::NUM_ENTRIES_DEF,
    parameter int MAX_LEN     = wstm_pkg::MAX_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic [2:0] s_axis_tuser,   // [1:0] func, [2] empty_req
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] found, [5:1] match_index, [7:6] zero
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic                          adv;
    logic [ADDR_W-1:0]             ram_addr;
    logic [wstm_pkg::CHAR_W-1:0]   ram_wdata;
    logic [NUM_ENTRIES-1:0]        ram_we;
    logic                          s1_valid;
    wstm_pkg::s1_ctrl_t            s1_ctrl;
    logic [wstm_pkg::CHAR_W-1:0]   s1_ch;
    logic [NUM_ENTRIES-1:0]        s1_lane_ok;
    logic [NUM_ENTRIES-1:0]        s1_len_eq;
    logic                          res_valid;
    logic [wstm_pkg::STATUS_W-1:0] res_status;
    logic                          res_found;
    logic [wstm_pkg::INDEX_W-1:0]  res_index;

    logic                          out_valid_reg;
    logic [wstm_pkg::STATUS_W-1:0] out_status_reg;
    logic                          out_found_reg;
    logic [wstm_pkg::INDEX_W-1:0]  out_index_reg;

    // The compare stage moves on unless it holds a result with nowhere to go.
    assign adv = ~res_valid | ~out_valid_reg | m_axis_tready;
    assign s_axis_tready = adv;

    wstm_front #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .MAX_LEN     (MAX_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_axis_tvalid),
        .in_func    (s_axis_tuser[1:0]),
        .in_ch      (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .in_empty   (s_axis_tuser[2]),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_we     (ram_we),
        .s1_valid   (s1_valid),
        .s1_ctrl    (s1_ctrl),
        .s1_ch      (s1_ch),
        .s1_lane_ok (s1_lane_ok),
        .s1_len_eq  (s1_len_eq)
    );

    wstm_match #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .MAX_LEN     (MAX_LEN)
    ) u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_we     (ram_we),
        .s1_valid   (s1_valid),
        .s1_ctrl    (s1_ctrl),
        .s1_ch      (s1_ch),
        .s1_lane_ok (s1_lane_ok),
        .s1_len_eq  (s1_len_eq),
        .res_valid  (res_valid),
        .res_status (res_status),
        .res_found  (res_found),
        .res_index  (res_index)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && res_valid) begin
            out_status_reg <= res_status;
            out_found_reg  <= res_found;
            out_index_reg  <= res_index;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_index_reg, out_found_reg};

`ifndef NO_ASSERTIONS
    // Input is only refused while a finished result waits on a stalled receiver.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without a stalled result");

    // Entry results never report a match.
    a_entry_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != wstm_pkg::STATUS_ANSWERED) |->
        (m_axis_tdata[0] == 1'b0 && m_axis_tdata[5:1] == '0))
        else $error("entry result carries a match");

    // A query that found nothing reports index zero.
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == '0))
        else $error("miss with non-zero index");
`endif

endmodule

// File: design/wstm_ram.sv
// ----------------------------------------------------------------------------
// wstm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wstm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/wstm_front.sv
// ----------------------------------------------------------------------------
// wstm_front
// Decodes each transfer, tracks the string in progress, the stored lengths
// and the entry count, and drives the character RAMs.
// ----------------------------------------------------------------------------
module wstm_front #(
    parameter int NUM_ENTRIES = wstm_pkg::NUM_ENTRIES_DEF,
    parameter int MAX_LEN     = wstm_pkg::MAX_LEN_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  logic                                     in_valid,
    input  logic [wstm_pkg::FUNC_W-1:0]              in_func,
    input  logic [wstm_pkg::CHAR_W-1:0]              in_ch,
    input  logic                                     in_last,
    input  logic                                     in_empty,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] ram_addr,
    output logic [wstm_pkg::CHAR_W-1:0]              ram_wdata,
    output logic [NUM_ENTRIES-1:0]                   ram_we,
    output logic                                     s1_valid,
    output wstm_pkg::s1_ctrl_t                       s1_ctrl,
    output logic [wstm_pkg::CHAR_W-1:0]              s1_ch,
    output logic [NUM_ENTRIES-1:0]                   s1_lane_ok,
    output logic [NUM_ENTRIES-1:0]                   s1_len_eq
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W  = $clog2(MAX_LEN + 2);
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

    wstm_pkg::kind_t   kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              ovl_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [LEN_W-1:0]  len_reg [NUM_ENTRIES];

    logic                s1_valid_reg;
    wstm_pkg::s1_ctrl_t  s1_ctrl_reg;
    logic [wstm_pkg::CHAR_W-1:0] s1_ch_reg;
    logic [NUM_ENTRIES-1:0] lane_ok_reg;
    logic [NUM_ENTRIES-1:0] len_eq_reg;

    logic              acc;
    logic              is_entry;
    logic              is_query;
    logic              is_clear;
    logic              item_ok;
    wstm_pkg::kind_t   kind_in;
    logic              fresh;
    logic [POS_W-1:0]  pos_cur;
    logic              ovl_cur;
    logic              has_char;
    logic              in_range;
    logic [POS_W-1:0]  pos_next;
    logic              ovl_next;
    logic              full;
    logic              store;
    logic [wstm_pkg::STATUS_W-1:0] status;
    logic [NUM_ENTRIES-1:0] lane_ok;
    logic [NUM_ENTRIES-1:0] len_eq;
    wstm_pkg::s1_ctrl_t ctrl_next;

    always_comb begin
        is_entry = 1'b0;
        is_query = 1'b0;
        is_clear = 1'b0;
        case (in_func)
            wstm_pkg::FUNC_ENTRY: is_entry = 1'b1;
            wstm_pkg::FUNC_QUERY: is_query = 1'b1;
            wstm_pkg::FUNC_CLEAR: is_clear = 1'b1;
            default:              is_entry = 1'b0;
        endcase
    end

    assign acc      = in_valid & adv;
    // An empty mark that does not end the string is ignored altogether.
    assign item_ok  = (is_entry | is_query) & ~(in_empty & ~in_last);
    assign kind_in  = is_entry ? wstm_pkg::KIND_ENTRY : wstm_pkg::KIND_QUERY;
    assign fresh    = (kind_reg != kind_in);
    assign pos_cur  = fresh ? '0 : pos_reg;
    assign ovl_cur  = fresh ? 1'b0 : ovl_reg;
    assign has_char = ~in_empty;
    assign in_range = (pos_cur < POS_W'(MAX_LEN));
    assign pos_next = (has_char && pos_cur <= POS_W'(MAX_LEN)) ? pos_cur + 1'b1 : pos_cur;
    assign ovl_next = ovl_cur | (has_char & ~in_range);
    assign full     = (count_reg >= CNT_W'(NUM_ENTRIES));
    assign store    = is_entry & in_last & ~full & ~ovl_next;

    always_comb begin
        if (is_query) begin
            status = wstm_pkg::STATUS_ANSWERED;
        end else if (full) begin
            status = wstm_pkg::STATUS_FULL;
        end else if (ovl_next) begin
            status = wstm_pkg::STATUS_LONG;
        end else begin
            status = wstm_pkg::STATUS_STORED;
        end
    end

    always_comb begin
        ctrl_next.is_query = is_query;
        ctrl_next.cmp      = is_query & has_char & in_range;
        ctrl_next.last     = in_last;
        ctrl_next.fresh    = fresh;
        ctrl_next.ovl      = ovl_next;
        ctrl_next.status   = status;
    end

    assign ram_addr  = pos_cur[ADDR_W-1:0];
    assign ram_wdata = in_ch;

    for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_lane
        logic live;
        assign live       = (CNT_W'(j) < count_reg);
        assign lane_ok[j] = live && (pos_cur < POS_W'(len_reg[j]));
        assign len_eq[j]  = live && (POS_W'(len_reg[j]) == pos_next);
        assign ram_we[j]  = acc & item_ok & is_entry & has_char & in_range & ~full &
                            (count_reg == CNT_W'(j));
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < NUM_ENTRIES; j++) begin
            if (acc && item_ok && store && count_reg == CNT_W'(j)) begin
                len_reg[j] <= pos_next[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= wstm_pkg::KIND_NONE;
            pos_reg      <= '0;
            ovl_reg      <= 1'b0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= acc & item_ok;
            end
            if (acc) begin
                if (is_clear) begin
                    count_reg <= '0;
                    kind_reg  <= wstm_pkg::KIND_NONE;
                    pos_reg   <= '0;
                    ovl_reg   <= 1'b0;
                end else if (item_ok) begin
                    if (in_last) begin
                        kind_reg <= wstm_pkg::KIND_NONE;
                        pos_reg  <= '0;
                        ovl_reg  <= 1'b0;
                        if (store) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end else begin
                        kind_reg <= kind_in;
                        pos_reg  <= pos_next;
                        ovl_reg  <= ovl_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctrl_reg <= ctrl_next;
            s1_ch_reg   <= in_ch;
            lane_ok_reg <= lane_ok;
            len_eq_reg  <= len_eq;
        end
    end

    assign s1_valid   = s1_valid_reg;
    assign s1_ctrl    = s1_ctrl_reg;
    assign s1_ch      = s1_ch_reg;
    assign s1_lane_ok = lane_ok_reg;
    assign s1_len_eq  = len_eq_reg;

endmodule

// File: design/wstm_match.sv
// ----------------------------------------------------------------------------
// wstm_match
// One character RAM per table entry, the parallel character compare, the
// candidate vector and the first-match search.
// ----------------------------------------------------------------------------
module wstm_match #(
    parameter int NUM_ENTRIES = wstm_pkg::NUM_ENTRIES_DEF,
    parameter int MAX_LEN     = wstm_pkg::MAX_LEN_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] ram_addr,
    input  logic [wstm_pkg::CHAR_W-1:0]              ram_wdata,
    input  logic [NUM_ENTRIES-1:0]                   ram_we,
    input  logic                                     s1_valid,
    input  wstm_pkg::s1_ctrl_t                       s1_ctrl,
    input  logic [wstm_pkg::CHAR_W-1:0]              s1_ch,
    input  logic [NUM_ENTRIES-1:0]                   s1_lane_ok,
    input  logic [NUM_ENTRIES-1:0]                   s1_len_eq,
    output logic                                     res_valid,
    output logic [wstm_pkg::STATUS_W-1:0]            res_status,
    output logic                                     res_found,
    output logic [wstm_pkg::INDEX_W-1:0]             res_index
);

    logic [NUM_ENTRIES-1:0] cand_reg;
    logic [NUM_ENTRIES-1:0] cand_base;
    logic [NUM_ENTRIES-1:0] hit;
    logic [NUM_ENTRIES-1:0] cand_next;
    logic [NUM_ENTRIES-1:0] match_vec;
    logic [wstm_pkg::INDEX_W-1:0] first_idx;

    for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_lane
        logic [wstm_pkg::CHAR_W-1:0] rd;

        wstm_ram #(
            .WIDTH (wstm_pkg::CHAR_W),
            .DEPTH (MAX_LEN)
        ) u_chars (
            .aclk  (aclk),
            .we    (ram_we[j]),
            .waddr (ram_addr),
            .wdata (ram_wdata),
            .re    (adv),
            .raddr (ram_addr),
            .rdata (rd)
        );

        assign hit[j] = (rd == s1_ch) || (rd == wstm_pkg::WILDCARD) ||
                        (s1_ch == wstm_pkg::WILDCARD);
    end

    // The first character of a new string starts from a full candidate set.
    assign cand_base = s1_ctrl.fresh ? '1 : cand_reg;
    assign cand_next = s1_ctrl.cmp ? (cand_base & s1_lane_ok & hit) : cand_base;
    assign match_vec = cand_next & s1_len_eq & {NUM_ENTRIES{~s1_ctrl.ovl}};

    always_comb begin
        first_idx = '0;
        for (int j = NUM_ENTRIES - 1; j >= 0; j--) begin
            if (match_vec[j]) begin
                first_idx = wstm_pkg::INDEX_W'(j + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '1;
        end else if (s1_valid && adv) begin
            cand_reg <= cand_next;
        end
    end

    assign res_valid  = s1_valid & s1_ctrl.last;
    assign res_status = s1_ctrl.status;
    assign res_found  = s1_ctrl.is_query & (|match_vec);
    assign res_index  = s1_ctrl.is_query ? first_idx : '0;

endmodule
